/* rtl/core/sle_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types for the sequential list engine: action codes and the command
// and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sle_pkg;

  typedef enum logic [2:0] {
    ACT_APPEND = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_READ   = 3'd2,
    ACT_SWAP   = 3'd3,
    ACT_REMOVE = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ASEL_POS_A,
    ASEL_POS_B,
    ASEL_TAIL,
    ASEL_HEAD
  } addr_sel_t;

  typedef enum logic [1:0] {
    WSEL_INPUT,
    WSEL_RDATA,
    WSEL_HOLD
  } wdata_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_SUB
  } cnt_op_t;

  typedef struct packed {
    logic       load;
    logic       rd_en;
    addr_sel_t  rd_sel;
    logic       wr_en;
    addr_sel_t  wr_sel;
    wdata_sel_t wd_sel;
    logic       hold_en;
    logic       move_init;
    logic       move_run;
    cnt_op_t    cnt_op;
    logic       emit;
    logic       emit_err;
    logic       emit_data;
  } cmd_t;

  typedef struct packed {
    logic [2:0] act;
    logic       req_ok;
    logic       move_idle;
  } sts_t;

endpackage

/* rtl/core/sle_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_datapath
// Entry memory, fill count, request register, block move unit and result
// registers of the sequential list engine.
// ----------------------------------------------------------------------------
module sle_datapath
  import sle_pkg::*;
#(
  parameter int DEPTH        = 64,
  parameter int RECORD_WIDTH = 64,
  parameter int PW           = $clog2(DEPTH + 1),
  parameter int AW           = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  input  logic [2:0]              action,
  input  logic [RECORD_WIDTH-1:0] element_in,
  input  logic [PW-1:0]           pos_a,
  input  logic [PW-1:0]           pos_b,
  output logic                    done,
  output logic                    status,
  output logic [RECORD_WIDTH-1:0] element_out,
  output logic [PW-1:0]           count
);

  logic [RECORD_WIDTH-1:0] mem [DEPTH];
  logic [RECORD_WIDTH-1:0] rd_data;
  logic [RECORD_WIDTH-1:0] hold;

  logic [2:0]              req_act;
  logic [RECORD_WIDTH-1:0] req_word;
  logic [PW-1:0]           req_a;
  logic [PW-1:0]           req_b;
  logic [PW-1:0]           fill;

  logic [AW-1:0]           src;
  logic [AW-1:0]           dst;
  logic [PW-1:0]           remaining;
  logic                    dir_down;
  logic                    pend;
  logic [AW-1:0]           pend_addr;

  logic                    ok;
  logic [PW-1:0]           gone;
  logic [PW-1:0]           a_m1;
  logic [PW-1:0]           b_m1;
  logic                    rd_go;
  logic [AW-1:0]           rd_addr;
  logic                    wr_go;
  logic [AW-1:0]           wr_addr;
  logic [RECORD_WIDTH-1:0] wr_data;
  logic                    mv_read;

  assign a_m1 = req_a - PW'(1);
  assign b_m1 = req_b - PW'(1);
  assign gone = req_b - a_m1;

  always_comb begin
    case (req_act)
      ACT_APPEND, ACT_INSERT: ok = (fill != PW'(DEPTH));
      ACT_READ:   ok = (req_a != '0) && (req_a <= fill);
      ACT_SWAP:   ok = (req_a != req_b) && (req_a != '0) && (req_b != '0) &&
                       (req_a <= fill) && (req_b <= fill);
      ACT_REMOVE: ok = (req_a < req_b) && (req_a != '0) &&
                       (req_a <= fill) && (req_b <= fill);
      default:    ok = 1'b0;
    endcase
  end

  assign sts.act       = req_act;
  assign sts.req_ok    = ok;
  assign sts.move_idle = (remaining == '0) && !pend;

  function automatic logic [AW-1:0] sel_addr(addr_sel_t s, logic [PW-1:0] am1,
                                             logic [PW-1:0] bm1, logic [PW-1:0] f);
    logic [AW-1:0] r;
    case (s)
      ASEL_POS_A: r = am1[AW-1:0];
      ASEL_POS_B: r = bm1[AW-1:0];
      ASEL_TAIL:  r = f[AW-1:0];
      default:    r = '0;
    endcase
    return r;
  endfunction

  assign mv_read = cmd.move_run && (remaining != '0);

  always_comb begin
    rd_go   = mv_read || cmd.rd_en;
    rd_addr = mv_read ? src : sel_addr(cmd.rd_sel, a_m1, b_m1, fill);
    wr_go   = pend || cmd.wr_en;
    if (pend) begin
      wr_addr = pend_addr;
      wr_data = rd_data;
    end else begin
      wr_addr = sel_addr(cmd.wr_sel, a_m1, b_m1, fill);
      case (cmd.wd_sel)
        WSEL_RDATA: wr_data = rd_data;
        WSEL_HOLD:  wr_data = hold;
        default:    wr_data = req_word;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_go) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_go) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_act  <= action;
      req_word <= element_in;
      req_a    <= pos_a;
      req_b    <= pos_b;
    end
    if (cmd.hold_en) begin
      hold <= rd_data;
    end
    if (cmd.move_init) begin
      if (req_act == ACT_INSERT) begin
        dir_down <= 1'b1;
        src      <= AW'(fill - PW'(1));
        dst      <= fill[AW-1:0];
      end else begin
        dir_down <= 1'b0;
        src      <= req_b[AW-1:0];
        dst      <= a_m1[AW-1:0];
      end
    end else if (mv_read) begin
      src       <= dir_down ? src - AW'(1) : src + AW'(1);
      dst       <= dir_down ? dst - AW'(1) : dst + AW'(1);
      pend_addr <= dst;
    end
    if (cmd.emit) begin
      element_out <= cmd.emit_data ? rd_data : '0;
      status      <= cmd.emit_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      remaining <= '0;
      pend      <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= cmd.emit;
      case (cmd.cnt_op)
        CNT_INC: fill <= fill + PW'(1);
        CNT_SUB: fill <= fill - gone;
        default: fill <= fill;
      endcase
      if (cmd.move_init) begin
        remaining <= (req_act == ACT_INSERT) ? fill : fill - req_b;
        pend      <= 1'b0;
      end else if (mv_read) begin
        remaining <= remaining - PW'(1);
        pend      <= 1'b1;
      end else begin
        pend <= 1'b0;
      end
    end
  end

  assign count = fill;

endmodule

/* rtl/core/sle_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_controller
// Request sequencer of the sequential list engine: decodes the latched item
// and steps the datapath through reads, writes and block moves.
// ----------------------------------------------------------------------------
module sle_controller
  import sle_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ_WAIT,
    S_SWAP_B,
    S_SWAP_WA,
    S_SWAP_WB,
    S_MOVE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = ASEL_POS_A;
    cmd.wr_sel = ASEL_HEAD;
    cmd.wd_sel = WSEL_INPUT;
    cmd.cnt_op = CNT_HOLD;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts.req_ok) begin
          cmd.emit     = 1'b1;
          cmd.emit_err = 1'b1;
          state_next   = S_IDLE;
        end else begin
          case (sts.act)
            ACT_APPEND: begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = ASEL_TAIL;
              cmd.cnt_op = CNT_INC;
              cmd.emit   = 1'b1;
              state_next = S_IDLE;
            end
            ACT_READ: begin
              cmd.rd_en  = 1'b1;
              state_next = S_READ_WAIT;
            end
            ACT_SWAP: begin
              cmd.rd_en  = 1'b1;
              state_next = S_SWAP_B;
            end
            default: begin
              cmd.move_init = 1'b1;
              state_next    = S_MOVE;
            end
          endcase
        end
      end
      S_READ_WAIT: begin
        cmd.emit      = 1'b1;
        cmd.emit_data = 1'b1;
        state_next    = S_IDLE;
      end
      S_SWAP_B: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = ASEL_POS_B;
        cmd.hold_en = 1'b1;
        state_next  = S_SWAP_WA;
      end
      S_SWAP_WA: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = ASEL_POS_A;
        cmd.wd_sel = WSEL_RDATA;
        state_next = S_SWAP_WB;
      end
      S_SWAP_WB: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = ASEL_POS_B;
        cmd.wd_sel = WSEL_HOLD;
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      S_MOVE: begin
        cmd.move_run = 1'b1;
        if (sts.move_idle) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
          if (sts.act == ACT_INSERT) begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = ASEL_HEAD;
            cmd.cnt_op = CNT_INC;
          end else begin
            cmd.cnt_op = CNT_SUB;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

/* rtl/core/sequential_list_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequential_list_engine
// Fixed-capacity ordered list of record words: append, front insert, read,
// swap and range removal over an entry memory with one read and one write port.
// ----------------------------------------------------------------------------
// Append and rejected items complete from decode; read waits for the memory
// read, swap reads both entries and writes them back crosswise, and front insert
// and range removal run a block move that copies one entry per cycle through
// the memory.
// A new item is accepted in the cycle done is high; results cannot be stalled.
// Synchronous reset empties the list; entry contents are not cleared.
// ----------------------------------------------------------------------------
module sequential_list_engine
  import sle_pkg::*;
#(
  parameter int DEPTH        = 64,
  parameter int RECORD_WIDTH = 64,
  parameter int PW           = $clog2(DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              action,
  input  logic [RECORD_WIDTH-1:0] element_in,
  input  logic [PW-1:0]           pos_a,
  input  logic [PW-1:0]           pos_b,
  output logic                    done,
  output logic                    status,
  output logic [RECORD_WIDTH-1:0] element_out,
  output logic [PW-1:0]           count
);

  cmd_t cmd;
  sts_t sts;

  sle_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  sle_datapath #(
    .DEPTH        (DEPTH),
    .RECORD_WIDTH (RECORD_WIDTH),
    .PW           (PW)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .action      (action),
    .element_in  (element_in),
    .pos_a       (pos_a),
    .pos_b       (pos_b),
    .done        (done),
    .status      (status),
    .element_out (element_out),
    .count       (count)
  );

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a request in flight");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not start work");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= PW'(DEPTH))
    else $error("entry count above capacity");

  a_count_stable_idle: assert property (@(posedge clk) disable iff (rst)
    !busy && !$past(busy) && !$past(rst) |-> $stable(count))
    else $error("entry count moved while idle");

endmodule

/* verif/sequential_list_engine_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequential_list_engine_tb
// Self-checking bench for the list engine. A directed run covers the empty
// list, bad positions and unknown actions. A fill-to-capacity run and
// randomized list traffic follow. Every request is predicted by a local model
// of the list, and each strobed result is compared field by field.
// ----------------------------------------------------------------------------
module sequential_list_engine_tb
  import sle_pkg::*;
();

  localparam int DEPTH         = 64;
  localparam int RECORD_WIDTH  = 64;
  localparam int PW            = $clog2(DEPTH + 1);
  localparam int STALL_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 80;
  localparam logic [2:0] ACT_FIRST_UNKNOWN = 3'(ACT_REMOVE) + 3'd1;
  localparam logic [2:0] ACT_LAST_CODE     = 3'b111;

  typedef struct {
    logic                    status;
    logic [RECORD_WIDTH-1:0] element;
    logic [PW-1:0]           count;
  } list_result_t;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic [2:0]              action;
  logic [RECORD_WIDTH-1:0] element_in;
  logic [PW-1:0]           pos_a;
  logic [PW-1:0]           pos_b;
  logic                    done;
  logic                    status;
  logic [RECORD_WIDTH-1:0] element_out;
  logic [PW-1:0]           count;

  logic [RECORD_WIDTH-1:0] list_mem [DEPTH];
  int                      list_fill;
  list_result_t            pending_results[$];
  int                      mismatches;
  int                      stall_cycles;
  bit                      idling_on;

  sequential_list_engine #(
    .DEPTH        (DEPTH),
    .RECORD_WIDTH (RECORD_WIDTH)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .element_in  (element_in),
    .pos_a       (pos_a),
    .pos_b       (pos_b),
    .done        (done),
    .status      (status),
    .element_out (element_out),
    .count       (count)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic list_result_t apply_request(logic [2:0] act,
                                                 logic [RECORD_WIDTH-1:0] word,
                                                 logic [PW-1:0] pa,
                                                 logic [PW-1:0] pb);
    list_result_t            res;
    logic [RECORD_WIDTH-1:0] held;
    int                      span;
    res.status  = 1'b1;
    res.element = '0;
    case (act)
      ACT_APPEND: begin
        if (list_fill < DEPTH) begin
          list_mem[list_fill] = word;
          list_fill++;
          res.status = 1'b0;
        end
      end
      ACT_INSERT: begin
        if (list_fill < DEPTH) begin
          for (int i = list_fill; i > 0; i--) list_mem[i] = list_mem[i-1];
          list_mem[0] = word;
          list_fill++;
          res.status = 1'b0;
        end
      end
      ACT_READ: begin
        if (pa != 0 && pa <= list_fill) begin
          res.status  = 1'b0;
          res.element = list_mem[pa-1];
        end
      end
      ACT_SWAP: begin
        if (pa != pb && pa != 0 && pb != 0 && pa <= list_fill && pb <= list_fill) begin
          held          = list_mem[pa-1];
          list_mem[pa-1] = list_mem[pb-1];
          list_mem[pb-1] = held;
          res.status    = 1'b0;
        end
      end
      ACT_REMOVE: begin
        if (pa < pb && pa != 0 && pa <= list_fill && pb <= list_fill) begin
          span = pb - pa + 1;
          for (int i = pa - 1; i + span < list_fill; i++) list_mem[i] = list_mem[i+span];
          list_fill -= span;
          res.status = 1'b0;
        end
      end
      default: ;
    endcase
    res.count = PW'(list_fill);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [RECORD_WIDTH-1:0] got,
                                 logic [RECORD_WIDTH-1:0] want);
    $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic send_item(logic [2:0] act, logic [RECORD_WIDTH-1:0] word,
                           logic [PW-1:0] pa, logic [PW-1:0] pb);
    @(negedge clk);
    if (idling_on && $urandom_range(0, 99) < 35) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start      = 1'b1;
    action     = act;
    element_in = word;
    pos_a      = pa;
    pos_b      = pb;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(apply_request(act, word, pa, pb));
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [RECORD_WIDTH-1:0] random_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, count", RECORD_WIDTH'(count), '0);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          report_mismatch("status", RECORD_WIDTH'(status), RECORD_WIDTH'(want.status));
        if (element_out !== want.element) report_mismatch("element_out", element_out,
                                                          want.element);
        if (count !== want.count)
          report_mismatch("count", RECORD_WIDTH'(count), RECORD_WIDTH'(want.count));
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no item accepted for %0d cycles", STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic test_directed_cases();
    send_item(ACT_READ,   '0, 1, 0);
    send_item(ACT_REMOVE, '0, 1, 2);
    send_item(ACT_APPEND, '0, 0, 0);
    send_item(ACT_APPEND, '1, 0, 0);
    send_item(ACT_INSERT, 64'hA5C3_0F96_5A3C_F069, 0, 0);
    send_item(ACT_READ,   '0, 3, 0);
    send_item(ACT_READ,   '0, 0, 0);
    send_item(ACT_READ,   '0, 4, 0);
    send_item(ACT_SWAP,   '0, 1, 3);
    send_item(ACT_SWAP,   '0, 2, 2);
    send_item(ACT_SWAP,   '0, 0, 1);
    send_item(ACT_SWAP,   '0, 1, 4);
    send_item(ACT_REMOVE, '0, 2, 2);
    send_item(ACT_REMOVE, '0, 3, 2);
    send_item(ACT_REMOVE, '0, 0, 2);
    send_item(ACT_REMOVE, '0, 2, 4);
    for (int code = ACT_FIRST_UNKNOWN; code <= ACT_LAST_CODE; code++)
      send_item(3'(code), '1, 1, 2);
    send_item(ACT_APPEND, 64'h0123_4567_89AB_CDEF, 0, 0);
    send_item(ACT_APPEND, 64'hFEDC_BA98_7654_3210, 0, 0);
    send_item(ACT_REMOVE, '0, 2, 3);
    send_item(ACT_READ,   '0, 2, 0);
    send_item(ACT_REMOVE, '0, 1, 3);
  endtask

  task automatic test_full_list();
    while (list_fill < DEPTH)
      send_item($urandom_range(0, 1) ? ACT_APPEND : ACT_INSERT, random_word(), 0, 0);
    send_item(ACT_APPEND, random_word(), 0, 0);
    send_item(ACT_INSERT, random_word(), 0, 0);
    send_item(ACT_READ,   '0, PW'(DEPTH), 0);
    send_item(ACT_SWAP,   '0, 1, PW'(DEPTH));
    send_item(ACT_READ,   '0, 1, 0);
    send_item(ACT_REMOVE, '0, 2, PW'(DEPTH));
    send_item(ACT_REMOVE, '0, 1, 1);
  endtask

  task automatic send_random_item(int grow_pct);
    logic [2:0]              act;
    logic [RECORD_WIDTH-1:0] word;
    logic [PW-1:0]           pa;
    logic [PW-1:0]           pb;
    int                      pick;
    int                      len;
    word = random_word();
    pa   = 1;
    pb   = 2;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < grow_pct) begin
      act = $urandom_range(0, 1) ? ACT_APPEND : ACT_INSERT;
    end else if (pick < 30) begin
      act = ACT_READ;
      if (list_fill > 0) pa = PW'($urandom_range(1, list_fill));
    end else if (pick < 55) begin
      act = ACT_SWAP;
      if (list_fill > 1) begin
        pa = PW'($urandom_range(1, list_fill));
        pb = PW'($urandom_range(1, list_fill - 1));
        if (pb >= pa) pb++;
      end
    end else if (pick < 80) begin
      act = ACT_REMOVE;
      if (list_fill > 1) begin
        pa  = PW'($urandom_range(1, list_fill - 1));
        len = list_fill - pa;
        if ($urandom_range(0, 9) != 0 && len > 6) len = 6;
        pb  = PW'(pa + $urandom_range(1, len));
      end
    end else begin
      act = 3'($urandom_range(0, ACT_LAST_CODE));
      pa  = PW'($urandom_range(0, DEPTH));
      pb  = PW'($urandom_range(0, DEPTH));
    end
    send_item(act, word, pa, pb);
  endtask

  task automatic test_random_traffic();
    idling_on = 1'b0;
    repeat (300) send_random_item(55);
    idling_on = 1'b1;
    repeat (350) send_random_item(40);
    wait_for_results();
    repeat (350) send_random_item(50);
  endtask

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    action     = 3'(ACT_APPEND);
    element_in = '0;
    pos_a      = '0;
    pos_b      = '0;
    list_fill  = 0;
    mismatches = 0;
    idling_on  = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_cases();
    test_full_list();
    test_random_traffic();

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results still expected", RECORD_WIDTH'(pending_results.size()), '0);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
